[src/packed_bit_array_store_macros.svh]
// Assertion macros used by the packed bit array store module.
`ifndef PACKED_BIT_ARRAY_STORE_MACROS_SVH
`define PACKED_BIT_ARRAY_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBAS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packed_bit_array_store: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PBAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packed_bit_array_store: next-cycle check failed");

`endif

[src/pbas_pkg.sv]
// Shared types, codes and helper functions of the packed bit array store.
package pbas_pkg;

  localparam int unsigned STORE_WORDS_DEF = 1024;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned END_W   = 17;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BPV_W   = 7;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned IN_W    = 104;
  localparam int unsigned OUT_W   = 72;
  localparam int unsigned CFG_W   = 17;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_BITS_PER_VALUE = 1'b0,
    CFG_VALUE_COUNT    = 1'b1
  } cfg_reg_t;

  // Shift and mask that place one entry inside a two-word window.
  typedef struct packed {
    logic [6:0]  shamt;
    logic [63:0] mask;
  } merge_ctrl_t;

  // A width of zero acts as one, anything above 64 acts as 64.
  function automatic logic [6:0] eff_width(input logic [6:0] bpv);
    logic [6:0] w;
    if (bpv == 7'd0) begin
      w = 7'd1;
    end else if (bpv > 7'd64) begin
      w = 7'd64;
    end else begin
      w = bpv;
    end
    return w;
  endfunction

  function automatic logic [63:0] width_mask(input logic [6:0] w);
    return ~64'd0 >> (7'd64 - w);
  endfunction

endpackage

[src/pbas_merge.sv]
// Extracts or inserts one entry in a 128-bit window of two adjacent words.
module pbas_merge (
  input  logic [127:0]          win,
  input  pbas_pkg::merge_ctrl_t ctrl,
  input  logic [63:0]           value,
  output logic [63:0]           rd_out,
  output logic [127:0]          merged
);

  logic [127:0] shifted;
  logic [127:0] field_mask;
  logic [127:0] field_val;

  assign shifted    = win >> ctrl.shamt;
  assign rd_out     = shifted[63:0] & ctrl.mask;
  assign field_mask = {64'd0, ctrl.mask} << ctrl.shamt;
  assign field_val  = {64'd0, value & ctrl.mask} << ctrl.shamt;
  assign merged     = (win & ~field_mask) | field_val;

endmodule

[src/packed_bit_array_store.sv]
// Read/write: start position, limit and bounds check, then the RAM read and, for a
// write, merge and write-back; a failed bounds check skips the RAM. Fill: the same
// checks, then a read-modify-write per entry. Clear all: one word written per cycle.
// One request at a time; the word RAM and the shared multiply/add unit serve all steps.
// Reset (rst, synchronous): control and config registers return to defaults, then a
// clearing pass zeroes every RAM word with s_tready low; config writes still land.
`include "packed_bit_array_store_macros.svh"

module packed_bit_array_store #(
  parameter int unsigned STORE_WORDS = pbas_pkg::STORE_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [pbas_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // mode[1:0], index[17:2], end_index[34:18], value[98:35], zero pad above
  input  logic [pbas_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // read_value[63:0], status[64], zero pad above
  output logic [pbas_pkg::OUT_W-1:0] m_tdata
);

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [pbas_pkg::POS_W-1:0] STORE_BITS = pbas_pkg::POS_W'(STORE_WORDS * 64);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_LIMIT, S_CHECK, S_RD0, S_RD1, S_RD2,
    S_MOD, S_WR1, S_NEXT, S_CLEAR, S_DONE
  } state_t;

  state_t state;

  logic [6:0]                      bits_per_value;
  logic [pbas_pkg::COUNT_W-1:0]    value_count;

  logic [1:0]                      mode_r;
  logic [pbas_pkg::INDEX_W-1:0]    idx_r;
  logic [pbas_pkg::END_W-1:0]      end_r;
  logic [63:0]                     val_r;
  logic [pbas_pkg::POS_W-1:0]      pos;
  logic [pbas_pkg::POS_W-1:0]      lim;
  logic [pbas_pkg::END_W-1:0]      cnt;
  logic [63:0]                     w0;
  logic [63:0]                     w1;
  logic [AW-1:0]                   clr_addr;
  logic                            clr_reply;
  logic [63:0]                     res_value;
  logic                            res_status;
  logic [63:0]                     out_value;
  logic                            out_status;

  logic [63:0]                     mem [STORE_WORDS];
  logic [63:0]                     mem_rdata;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [63:0]                     mem_wdata;
  logic [AW-1:0]                   mem_raddr;

  logic [6:0]                      w;
  logic [pbas_pkg::END_W-1:0]      mul_a;
  logic [pbas_pkg::POS_W-1:0]      prod;
  logic [pbas_pkg::POS_W-1:0]      pos_plus_w;
  logic [5:0]                      off;
  logic [7:0]                      off_plus_w;
  logic                            straddle;
  logic [AW-1:0]                   word;
  logic [AW-1:0]                   word_p1;
  logic                            is_fill;
  logic                            err;
  pbas_pkg::merge_ctrl_t           mctrl;
  logic [63:0]                     rd_out;
  logic [127:0]                    merged;

  assign w = pbas_pkg::eff_width(bits_per_value);

  // Shared arithmetic: one multiplier for start and end positions, one position adder.
  assign mul_a      = (state == S_CALC) ? {1'b0, idx_r} : end_r;
  assign prod       = pbas_pkg::POS_W'(pbas_pkg::POS_W'(mul_a) * pbas_pkg::POS_W'(w));
  assign pos_plus_w = pos + pbas_pkg::POS_W'(w);

  assign off        = pos[5:0];
  assign off_plus_w = {2'b00, off} + {1'b0, w};
  assign straddle   = off_plus_w > 8'd64;
  assign word       = pos[6 +: AW];
  assign word_p1    = word + AW'(1);
  assign is_fill    = (mode_r == pbas_pkg::MODE_FILL);

  assign mctrl.shamt = 7'(8'd128 - off_plus_w);
  assign mctrl.mask  = pbas_pkg::width_mask(w);

  always_comb begin
    if (is_fill) begin
      err = ({1'b0, idx_r} > end_r) || (end_r > value_count) || (lim > STORE_BITS);
    end else begin
      err = ({1'b0, idx_r} >= value_count) || (lim > STORE_BITS);
    end
  end

  pbas_merge u_merge (
    .win    ({w0, w1}),
    .ctrl   (mctrl),
    .value  (val_r),
    .rd_out (rd_out),
    .merged (merged)
  );

  // RAM port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word;
    mem_wdata = merged[127:64];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_MOD && mode_r != pbas_pkg::MODE_READ) begin
      mem_we = 1'b1;
    end else if (state == S_WR1) begin
      mem_we    = 1'b1;
      mem_waddr = word_p1;
      mem_wdata = merged[63:0];
    end
  end

  assign mem_raddr = (state == S_RD1) ? word_p1 : word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_value <= 7'd8;
      value_count    <= pbas_pkg::COUNT_W'(8192);
    end else if (cfg_we) begin
      unique case (pbas_pkg::cfg_reg_t'(cfg_index))
        pbas_pkg::CFG_BITS_PER_VALUE: bits_per_value <= cfg_data[6:0];
        pbas_pkg::CFG_VALUE_COUNT:    value_count    <= cfg_data;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'd0, out_status, out_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode_r <= s_tdata[1:0];
            idx_r  <= s_tdata[17:2];
            end_r  <= s_tdata[34:18];
            val_r  <= s_tdata[98:35];
            if (s_tdata[1:0] == pbas_pkg::MODE_CLEAR) begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          pos   <= prod;
          state <= S_LIMIT;
        end
        S_LIMIT: begin
          lim   <= is_fill ? prod : pos_plus_w;
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_value  <= '0;
          res_status <= err;
          cnt        <= end_r - {1'b0, idx_r};
          if (err) begin
            state <= S_DONE;
          end else if (is_fill && end_r == {1'b0, idx_r}) begin
            state <= S_DONE;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          w0    <= mem_rdata;
          w1    <= '0;
          state <= straddle ? S_RD2 : S_MOD;
        end
        S_RD2: begin
          w1    <= mem_rdata;
          state <= S_MOD;
        end
        S_MOD: begin
          if (mode_r == pbas_pkg::MODE_READ) begin
            res_value <= rd_out;
            state     <= S_DONE;
          end else begin
            state <= straddle ? S_WR1 : S_NEXT;
          end
        end
        S_WR1: begin
          state <= S_NEXT;
        end
        S_NEXT: begin
          // A fill walks entry by entry; each entry starts one width further on.
          cnt <= cnt - pbas_pkg::END_W'(1);
          pos <= pos_plus_w;
          if (!is_fill || cnt == pbas_pkg::END_W'(1)) begin
            state <= S_DONE;
          end else begin
            state <= S_RD0;
          end
        end
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            res_value  <= '0;
            res_status <= 1'b0;
            state      <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PBAS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `PBAS_ASSERT_SAME(a_error_reads_zero, m_tvalid && out_status, out_value == 64'd0)
  `PBAS_ASSERT_SAME(a_result_from_done, $rose(m_tvalid), $past(state == S_DONE))
  `PBAS_ASSERT_SAME(a_no_idle_write, state == S_IDLE, !mem_we)

endmodule
